>>> design/ttli_pkg.sv
// Package for the time table linear interpolator.
// Holds sizes, region and address-select codes, and the command and status structs.
// No dependencies.
`default_nettype none

package ttli_pkg;

  localparam int ENTRIES    = 256;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int IDXF_W     = 8;    // interval_index and entry_index field width
  localparam int T_W        = 32;
  localparam int V_W        = 32;
  localparam int CNT_W      = 9;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int NUM_W      = 66;
  localparam int DEN_W      = 33;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 9'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REGION_BEFORE = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_AFTER  = 2'd2;

  localparam logic [1:0] RD_ZERO  = 2'd0;
  localparam logic [1:0] RD_CLAMP = 2'd1;
  localparam logic [1:0] RD_NEXT  = 2'd2;

  typedef struct packed {
    logic       accept_load;
    logic       accept_eval;
    logic [1:0] rd_sel;
    logic       chk0;
    logic       ldc;
    logic       set_end;
    logic       cmp;
    logic       mul_a;
    logic       mul_b;
    logic       sum;
    logic       div_start;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic t_le_rd;
    logic cur_eq_last;
    logic zero_len;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/ttli_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Quotient must fit DIV_STEPS bits (upper numerator part below the divisor).
// Depends on ttli_pkg.
`default_nettype none

module ttli_div
  import ttli_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_W-1:0]     num,
  input  wire logic [DEN_W-1:0]     den,
  output logic                      busy,
  output logic [DIV_STEPS-1:0]      quo
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_STEPS-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;

  assign trial = {rem_r, quo_r[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
      rem_nxt = num[NUM_W-2:DIV_STEPS];
      quo_nxt = num[DIV_STEPS-1:0];
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> design/ttli_dp.sv
// Datapath: table memories, cursor, interval registers, shared multiplier,
// divider operands and the output register. Depends on ttli_pkg.
`default_nettype none

module ttli_dp
  import ttli_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic                  cfg_we,
  input  wire logic [CNT_W-1:0]      cfg_value,
  input  wire logic [IDXF_W-1:0]     in_entry_index,
  input  wire logic [T_W-1:0]        in_entry_time,
  input  wire logic [V_W-1:0]        in_entry_value,
  input  wire logic [T_W-1:0]        in_query_time,
  output logic [NUM_W-1:0]           div_num,
  output logic [DEN_W-1:0]           div_den,
  input  wire logic [DIV_STEPS-1:0]  div_quo,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [V_W-1:0]             out_value,
  output logic [1:0]                 out_region,
  output logic [IDXF_W-1:0]          out_interval_index
);

  logic [T_W-1:0] time_mem [ENTRIES];
  logic [V_W-1:0] value_mem [ENTRIES];

  logic [CNT_W-1:0]      entry_count_r;
  logic [IDX_W-1:0]      cursor_r;
  logic [IDX_W-1:0]      last;
  logic                  cur_gt_last;
  logic [IDX_W-1:0]      rd_addr;
  logic [T_W-1:0]        rd_time_r;
  logic [V_W-1:0]        rd_val_r;
  logic [T_W-1:0]        t_r, t0_r, t1_r;
  logic signed [V_W-1:0] f0_r, f1_r;
  logic [V_W-1:0]        hold_val_r;
  logic                  use_div_r;
  logic [1:0]            region_r;
  logic signed [63:0]    s_r, prod_r;

  logic [T_W-1:0]        w0, w1, d;
  logic signed [V_W-1:0] mul_f;
  logic signed [T_W:0]   mul_w;
  logic signed [64:0]    mul_p;

  logic                  out_valid_r;
  logic [V_W-1:0]        out_value_r;
  logic [1:0]            out_region_r;
  logic [IDXF_W-1:0]     out_idx_r;

  // Last entry in use; a zero count acts as one, an oversize count as the full table.
  always_comb begin
    if (entry_count_r == '0) begin
      last = '0;
    end else if ({23'd0, entry_count_r} > 32'(ENTRIES)) begin
      last = IDX_W'(ENTRIES - 1);
    end else begin
      last = IDX_W'(entry_count_r - 9'd1);
    end
  end

  assign cur_gt_last = (cursor_r > last);

  always_comb begin
    case (cmd.rd_sel)
      RD_CLAMP: rd_addr = cur_gt_last ? '0 : cursor_r;
      RD_NEXT:  rd_addr = cursor_r + 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_load && (32'(in_entry_index) < ENTRIES)) begin
      time_mem[IDX_W'(in_entry_index)]  <= in_entry_time;
      value_mem[IDX_W'(in_entry_index)] <= in_entry_value;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_val_r  <= value_mem[rd_addr];
  end

  // Weights: t0 <= t <= t1 holds whenever the multiplier is used.
  assign w0 = t1_r - t_r;
  assign w1 = t_r - t0_r;
  assign d  = t1_r - t0_r;

  assign mul_f = cmd.mul_b ? f1_r : f0_r;
  assign mul_w = $signed({1'b0, (cmd.mul_b ? w1 : w0)});
  assign mul_p = mul_f * mul_w;

  // Rounded floor of S/d as floor((2S + d + d*2^32) / 2d); bias flips quotient bit 31.
  assign div_num = {s_r[63], s_r, 1'b0} + {2'b00, d, d};
  assign div_den = {d, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RESET;
      cursor_r      <= '0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_value;
      end
      if (cmd.accept_load) begin
        cursor_r <= '0;
      end else if (cmd.chk0 && !sts.t_le_rd && cur_gt_last) begin
        cursor_r <= '0;
      end else if (cmd.ldc && (t_r < rd_time_r)) begin
        cursor_r <= '0;
      end else if (cmd.cmp && !sts.t_le_rd) begin
        cursor_r <= cursor_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_eval) begin
      t_r <= in_query_time;
    end
    if (cmd.chk0) begin
      if (sts.t_le_rd) begin
        region_r   <= REGION_BEFORE;
        hold_val_r <= rd_val_r;
        use_div_r  <= 1'b0;
      end else begin
        t0_r <= rd_time_r;
        f0_r <= rd_val_r;
      end
    end
    // Going backward keeps entry 0, loaded at the first check.
    if (cmd.ldc && (t_r >= rd_time_r)) begin
      t0_r <= rd_time_r;
      f0_r <= rd_val_r;
    end
    if (cmd.set_end) begin
      region_r   <= REGION_AFTER;
      hold_val_r <= f0_r;
      use_div_r  <= 1'b0;
    end
    if (cmd.cmp) begin
      if (sts.t_le_rd) begin
        t1_r     <= rd_time_r;
        f1_r     <= rd_val_r;
        region_r <= REGION_INTERP;
      end else begin
        t0_r <= rd_time_r;
        f0_r <= rd_val_r;
      end
    end
    if (cmd.mul_a) begin
      s_r        <= mul_p[63:0];
      use_div_r  <= !sts.zero_len;
      hold_val_r <= f1_r;
    end
    if (cmd.mul_b) begin
      prod_r <= mul_p[63:0];
    end
    if (cmd.sum) begin
      s_r <= s_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= use_div_r ? {~div_quo[DIV_STEPS-1], div_quo[DIV_STEPS-2:0]}
                                : hold_val_r;
      out_region_r <= region_r;
      out_idx_r    <= (region_r == REGION_BEFORE) ? '0 : IDXF_W'(cursor_r);
    end
  end

  assign sts.t_le_rd     = (t_r <= rd_time_r);
  assign sts.cur_eq_last = (cursor_r == last);
  assign sts.zero_len    = (t1_r == t0_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_region         = out_region_r;
  assign out_interval_index = out_idx_r;

endmodule

`default_nettype wire

>>> design/ttli_ctrl.sv
// Controller state machine: sequences table lookup, cursor walk, multiply and divide.
// Drives dp_cmd_t to the datapath and the divider start. Depends on ttli_pkg.
`default_nettype none

module ttli_ctrl
  import ttli_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_opcode,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  input  wire logic    div_busy,
  output dp_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK0  = 4'd1;
  localparam logic [3:0] S_LDC   = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_MULA  = 4'd5;
  localparam logic [3:0] S_MULB  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_DIVGO = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_RES   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.accept_load = 1'b1;
          end else begin
            cmd.accept_eval = 1'b1;
            state_nxt       = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        cmd.chk0   = 1'b1;
        cmd.rd_sel = RD_CLAMP;
        state_nxt  = sts.t_le_rd ? S_RES : S_LDC;
      end
      S_LDC: begin
        cmd.ldc   = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (sts.cur_eq_last) begin
          cmd.set_end = 1'b1;
          state_nxt   = S_RES;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.t_le_rd ? S_MULA : S_STEP;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = sts.zero_len ? S_RES : S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (!div_busy) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> div_busy)
    else $error("divider not busy after start");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result emitted over an untaken word");

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_eval |=> (state_r == S_CHK0))
    else $error("evaluate word accepted without lookup");

  a_one_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept_load && cmd.accept_eval))
    else $error("load and evaluate accepted together");

endmodule

`default_nettype wire

>>> design/time_table_linear_interpolator.sv
// Time table linear interpolator: a 256-entry (time, value) table with a forward cursor.
// Input stream in_*: in_tuser = opcode (0 load entry, 1 evaluate); load words write one
//   entry and rewind the cursor, evaluate words produce one result word.
// Output stream out_*: out_tdata = value, interval_index; out_tuser = region.
// Config channel cfg_*: entry_count, always ready; write it only while idle.
// Steps per word, from acceptance to out_tvalid (states of ttli_ctrl):
//   load: no result; next word is taken in the following cycle.
//   at or before entry 0: CHK0, RES.  past the end: CHK0, LDC, a STEP and a CMP per
//   cursor advance (each waits on the registered table read), then STEP, RES.
//   interpolated: as past the end up to the final CMP, then MULA, MULB, SUM, DIVGO and
//   DIVW (the bit-per-cycle divider), RES.  zero-length interval: up to MULA, then RES.
// One word is in work at a time; the output register lets the next word be accepted
// while a result waits. If out_tready stays low, the next result holds in the
// controller until the output register frees.
// Reset (rst_n low, synchronous): cursor 0, entry_count 2, no output pending.
// Table contents are not cleared; read only entries that were loaded.
`default_nettype none

module time_table_linear_interpolator
  import ttli_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] entry_index, [39:8] entry_time, [71:40] entry_value, [103:72] query_time
  input  wire logic [103:0] in_tdata,
  // [0] opcode
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] value, [39:32] interval_index
  output logic [39:0]       out_tdata,
  // [1:0] region
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [8:0]   cfg_data
);

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic                 div_busy;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic [DIV_STEPS-1:0] div_quo;
  logic [V_W-1:0]       res_value;
  logic [1:0]           res_region;
  logic [IDXF_W-1:0]    res_idx;

  assign cfg_ready = 1'b1;

  ttli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser[0]),
    .in_ready  (in_tready),
    .sts       (sts),
    .div_busy  (div_busy),
    .cmd       (cmd)
  );

  ttli_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid),
    .cfg_value          (cfg_data),
    .in_entry_index     (in_tdata[7:0]),
    .in_entry_time      (in_tdata[39:8]),
    .in_entry_value     (in_tdata[71:40]),
    .in_query_time      (in_tdata[103:72]),
    .div_num            (div_num),
    .div_den            (div_den),
    .div_quo            (div_quo),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_value          (res_value),
    .out_region         (res_region),
    .out_interval_index (res_idx)
  );

  ttli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign out_tdata = {res_idx, res_value};
  assign out_tuser = res_region;

endmodule

`default_nettype wire

>>> sim/tb_time_table_linear_interpolator.sv
`timescale 1ns / 1ps
// Self-checking testbench for time_table_linear_interpolator: drives load/evaluate words,
// predicts each result with its own copy of the table and cursor, checks the out stream.
// Depends on ttli_pkg and the top-level RTL only.

module tb_time_table_linear_interpolator;
  import ttli_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [V_W-1:0]    value;
    logic [1:0]        region;
    logic [IDXF_W-1:0] interval;
  } interp_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // [7:0] entry_index, [39:8] entry_time, [71:40] entry_value,
                            // [103:72] query_time
  logic [0:0]   in_tuser;   // [0] opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;  // [31:0] value, [39:32] interval_index
  logic [1:0]   out_tuser;  // [1:0] region
  logic         cfg_valid;
  logic         cfg_ready;
  logic [8:0]   cfg_data;

  // predictor state
  logic [T_W-1:0]        tbl_time [ENTRIES];
  logic signed [V_W-1:0] tbl_value [ENTRIES];
  int                    cursor_pos;
  logic [CNT_W-1:0]      entry_count_reg;
  interp_result_t        pending_results[$];

  int  fail_count;
  int  cycle_count;
  int  walk_pos;
  bit  tx_idle_on;
  bit  rx_idle_on;
  int  rx_hold_req;
  int  rx_hold;
  int  rx_stall;
  bit  rx_waiting;

  time_table_linear_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ERROR: timeout after %0d cycles", $time, cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int used_count();
    if (entry_count_reg == 0) return 1;
    if (entry_count_reg > ENTRIES) return ENTRIES;
    return int'(entry_count_reg);
  endfunction

  // c*f0 + (1-c)*f1, exact sum then divide, round half toward +inf
  function automatic logic signed [V_W-1:0] blend_q16(input logic signed [V_W-1:0] f0,
                                                      input logic signed [V_W-1:0] f1,
                                                      input logic [T_W-1:0] t0,
                                                      input logic [T_W-1:0] t1,
                                                      input logic [T_W-1:0] t);
    longint lt0, lt1, lt, d, s, q, r;
    lt0 = {32'd0, t0};
    lt1 = {32'd0, t1};
    lt  = {32'd0, t};
    d = lt1 - lt0;
    if (d <= 0) return f1;
    s = longint'(f0) * (lt1 - lt) + longint'(f1) * (lt - lt0);
    q = s / d;
    r = s % d;
    if (r < 0) begin
      q = q - 1;
      r = r + d;
    end
    if (2 * r >= d) q = q + 1;
    return q[V_W-1:0];
  endfunction

  task automatic predict_query(input logic [T_W-1:0] t);
    interp_result_t res;
    int last;
    last = used_count() - 1;
    if (t <= tbl_time[0]) begin
      res.value    = tbl_value[0];
      res.region   = REGION_BEFORE;
      res.interval = '0;
    end else begin
      if (cursor_pos > last) cursor_pos = 0;
      if (t < tbl_time[cursor_pos]) cursor_pos = 0;
      while (cursor_pos < last &&
             !(t >= tbl_time[cursor_pos] && t <= tbl_time[cursor_pos+1]))
        cursor_pos++;
      if (cursor_pos < last) begin
        res.value  = blend_q16(tbl_value[cursor_pos], tbl_value[cursor_pos+1],
                               tbl_time[cursor_pos], tbl_time[cursor_pos+1], t);
        res.region = REGION_INTERP;
      end else begin
        res.value  = tbl_value[last];
        res.region = REGION_AFTER;
      end
      res.interval = cursor_pos[IDXF_W-1:0];
    end
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] rand_between(input logic [31:0] lo, input logic [31:0] hi);
    logic [63:0] span;
    logic [63:0] pick;
    if (hi <= lo) return lo;
    span = {32'd0, hi} - {32'd0, lo} + 64'd1;
    pick = {32'd0, $urandom} % span;
    return lo + pick[31:0];
  endfunction

  // mostly a forward walk through the table, plus jumps, exact hits and out-of-range times
  function automatic logic [31:0] pick_query(input int n);
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return ($urandom_range(3, 0) == 0) ? tbl_time[0] :
                tbl_time[0] >> $urandom_range(31, 0);
      2: return tbl_time[$urandom_range(n - 1, 0)];
      3: return (tbl_time[n-1] == '1) ? '1 : rand_between(tbl_time[n-1] + 1, '1);
      default: begin
        if (n < 2) return $urandom;
        walk_pos = (walk_pos + $urandom_range(2, 0)) % (n - 1);
        return rand_between(tbl_time[walk_pos], tbl_time[walk_pos+1]);
      end
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [7:0] idx, input logic [31:0] etime,
                           input logic [31:0] evalue, input logic [31:0] qtime);
    int gap;
    gap = tx_idle_on ? $urandom_range(3, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {qtime, evalue, etime, idx};
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      tbl_time[idx]  = etime;
      tbl_value[idx] = evalue;
      cursor_pos     = 0;
    end else begin
      predict_query(qtime);
    end
  endtask

  task automatic query(input logic [31:0] t);
    send_word(OP_EVAL, $urandom_range(255, 0), $urandom, $urandom, t);
  endtask

  task automatic load_entry(input int slot, input logic [31:0] t, input logic [31:0] v);
    send_word(OP_LOAD, slot[7:0], t, v, $urandom);
  endtask

  task automatic wait_idle(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // loads have no result, so wait on past the last result before the config write
  task automatic write_entry_count(input int n);
    wait_idle(8);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    entry_count_reg = n[CNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    out_tready = 1'b0;
    rx_hold    = 0;
    rx_stall   = 0;
    forever begin
      @(posedge clk);
      rx_waiting = out_tvalid && !out_tready;
      if (out_tvalid && out_tready) rx_stall = rx_idle_on ? $urandom_range(3, 0) : 0;
      @(negedge clk);
      if (rx_hold_req > 0) begin
        rx_hold     = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        out_tready <= 1'b0;
        if (rx_waiting) rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    interp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ERROR: unexpected result value %h region %0d interval %0d",
                 $time, out_tdata[31:0], out_tuser, out_tdata[39:32]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.value || out_tuser !== want.region ||
            out_tdata[39:32] !== want.interval) begin
          $display("%0t ERROR: expected value %h region %0d interval %0d, %s %h %0d %0d",
                   $time, want.value, want.region, want.interval, "actual",
                   out_tdata[31:0], out_tuser, out_tdata[39:32]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // two entries and the entry count left at its reset value
  task automatic test_reset_count();
    load_entry(0, 32'h0001_0000, 32'h0002_0000);
    load_entry(1, 32'h0003_0000, 32'hFFFE_0000);
    query(32'h0000_8000);
    query(32'h0002_0000);
    query(32'h0004_0000);
  endtask

  task automatic test_directed();
    load_entry(0, 32'h0000_0000, 32'h7FFF_FFFF);
    load_entry(1, 32'h0002_0000, 32'h8000_0000);
    load_entry(2, 32'h0005_0000, 32'h0001_2345);
    load_entry(3, 32'h0005_0000, 32'hFFFF_FFFF);
    load_entry(4, 32'hFFFF_FFFF, 32'h0000_0000);
    write_entry_count(3);
    query(32'h0000_0000);           // at first time
    query(32'h0000_0001);
    query(32'h0001_0000);           // exact half step between max and min
    query(32'h0004_0000);           // cursor advances
    query(32'h0005_0000);           // end of interval
    query(32'h0001_0000);           // time goes backward
    query(32'hFFFF_FFFF);           // past the end, cursor parks on last
    write_entry_count(4);
    query(32'h0005_0000);           // zero-length interval from parked cursor
    write_entry_count(5);
    query(32'hFFFF_FFFE);
    write_entry_count(1);           // cursor now beyond the count
    query(32'h0002_0000);
    query(32'h0000_0000);
    write_entry_count(0);           // zero count acts as one
    query(32'h0003_0000);
  endtask

  task automatic test_fill_table();
    logic [31:0] t;
    t = $urandom_range(1 << 20, 1);
    tx_idle_on = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      case ($urandom_range(7, 0))
        0: t = t;
        1: t = t + $urandom_range(16, 1);
        default: t = t + $urandom_range(1 << 23, 1);
      endcase
      load_entry(i, t, $urandom);
    end
  endtask

  // receiver holds off while the sender keeps offering, so in_tready must drop
  task automatic test_backpressure();
    write_entry_count(8);
    walk_pos    = 0;
    tx_idle_on  = 1'b0;
    rx_hold_req = 300;
    repeat (12) query(pick_query(used_count()));
    wait_idle(4);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (8) query(pick_query(used_count()));
    wait_idle($urandom_range(40, 10));
    repeat (8) query(pick_query(used_count()));
  endtask

  task automatic test_random_traffic();
    int n;
    int slot;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: n = 511;
        1: n = ENTRIES;
        default: begin
          case ($urandom_range(9, 0))
            0: n = 1;
            1: n = 2;
            6: n = $urandom_range(64, 17);
            7: n = ENTRIES;
            8: n = $urandom_range(511, ENTRIES + 1);
            9: n = 0;
            default: n = $urandom_range(16, 3);
          endcase
        end
      endcase
      write_entry_count(n);
      walk_pos   = 0;
      tx_idle_on = ($urandom_range(3, 0) != 0);
      rx_idle_on = ($urandom_range(3, 0) != 0);
      for (int k = 0; k < 35; k++) begin
        if ($urandom_range(6, 0) == 0) begin
          // keep the table mostly sorted, now and then drop in a wild time
          slot = $urandom_range(ENTRIES - 1, 0);
          lo = (slot == 0) ? '0 : tbl_time[slot-1];
          hi = (slot == ENTRIES - 1) ? '1 : tbl_time[slot+1];
          t = ($urandom_range(4, 0) == 0) ? $urandom : rand_between(lo, hi);
          load_entry(slot, t, $urandom);
        end else begin
          query(pick_query(used_count()));
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    rx_hold_req     = 0;
    cursor_pos      = 0;
    entry_count_reg = ENTRY_COUNT_RESET;
    walk_pos        = 0;
    fail_count      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_count();
    test_directed();
    test_fill_table();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();

    wait_idle(60);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
